// ===== src/apg_pkg.sv =====
// Shared types, constants and elaboration-time functions for the alpha premultiply core.
// Used by apg_log2, apg_exp2 and alpha_premultiply_gamma_core; depends on nothing else.
package apg_pkg;

    // Default parameter values.
    localparam int APG_SAMPLE_WIDTH    = 16;
    localparam int APG_GAMMA_FRAC_BITS = 12;

    // Fixed-point layout of the power path.
    localparam int APG_LOG_FRAC = 24;
    localparam int APG_LOG_W    = 28;
    localparam int APG_EXP_LEN  = 24;
    localparam int APG_FAC_W    = 17;

    // Pipeline depths of the log and exp units, in register stages.
    localparam int APG_LOG_LAT = APG_LOG_FRAC + 1;
    localparam int APG_EXP_LAT = APG_EXP_LEN + 2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_ASSOC = 3'd0;
    localparam logic [2:0] CFG_WIDE  = 3'd1;
    localparam logic [2:0] CFG_COUNT = 3'd2;
    localparam logic [2:0] CFG_ALPHA = 3'd3;
    localparam logic [2:0] CFG_GAMMA = 3'd4;

    // Register reset values.
    localparam logic        RST_ASSOC = 1'b1;
    localparam logic        RST_WIDE  = 1'b0;
    localparam logic [2:0]  RST_COUNT = 3'd4;
    localparam logic [1:0]  RST_ALPHA = 2'd3;
    localparam logic [15:0] RST_GAMMA = 16'd9011;

    // Per-pixel data that travels beside the power computation.
    typedef struct packed {
        logic [3:0][15:0] chan;
        logic             line_end;
        logic [15:0]      alpha;
        logic [3:0]       lanes;
        logic             int_path;
        logic             fac_one;
        logic             fac_zero;
        logic             wide;
    } t_side;

    // Integer square root rounded down, for constant arguments.
    function automatic logic [63:0] apg_isqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] rem;
        logic [63:0] bitv;
        res  = '0;
        rem  = v;
        bitv = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // floor(2^32 * 2^(-2^-(k+1))), for k = 0 .. APG_EXP_LEN-1.
    function automatic logic [63:0] apg_exp_tab(input int k);
        logic [63:0] t;
        t = apg_isqrt(64'h8000_0000_0000_0000);
        for (int j = 1; j <= k; j++) begin
            t = apg_isqrt(t << 32);
        end
        return t;
    endfunction

    // floor(log2(v) * 2^24) for a constant v >= 1.
    function automatic logic [63:0] apg_log2_const(input logic [63:0] v);
        int unsigned n;
        logic [63:0] m;
        logic [63:0] r;
        n = 0;
        r = '0;
        for (int i = 0; i < 31; i++) begin
            if ((v >> (n + 1)) != 0) begin
                n = n + 1;
            end
        end
        m = v << (31 - n);
        for (int i = 0; i < APG_LOG_FRAC; i++) begin
            m = (m * m) >> 31;
            r = r << 1;
            if (m >= 64'h1_0000_0000) begin
                r = r | 64'd1;
                m = m >> 1;
            end
        end
        return (64'(n) << APG_LOG_FRAC) | r;
    endfunction

endpackage

// ===== src/apg_log2.sv =====
// Pipelined fixed-point log2 of a 16-bit sample: floor(log2(v) * 2^24).
// Depends on apg_pkg; one normalize stage then one squaring stage per fraction bit.
module apg_log2
    import apg_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [15:0]          i_val,
    output logic                 o_valid,
    output logic [APG_LOG_W-1:0] o_lg
);

    logic [APG_LOG_FRAC:0]   r_vld;
    logic [31:0]             r_m [APG_LOG_FRAC+1];
    logic [3:0]              r_n [APG_LOG_FRAC+1];
    logic [APG_LOG_FRAC-1:0] r_r [APG_LOG_FRAC+1];

    logic [3:0]  n_n;
    logic [31:0] n_m;

    // Leading-one position gives the integer part; the mantissa is left aligned.
    always_comb begin
        n_n = '0;
        for (int i = 1; i < 16; i++) begin
            if (i_val[i]) begin
                n_n = 4'(i);
            end
        end
        n_m = {16'b0, i_val} << (5'd31 - {1'b0, n_n});
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[APG_LOG_FRAC-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_m[0] <= n_m;
        r_n[0] <= n_n;
        r_r[0] <= '0;
    end

    // One squaring per stage yields one fraction bit.
    for (genvar k = 1; k <= APG_LOG_FRAC; k++) begin : g_round
        logic [63:0] w_sq;
        logic [32:0] w_t;
        assign w_sq = r_m[k-1] * r_m[k-1];
        assign w_t  = w_sq[63:31];
        always_ff @(posedge i_clk) begin
            r_m[k] <= w_t[32] ? w_t[32:1] : w_t[31:0];
            r_n[k] <= r_n[k-1];
            r_r[k] <= {r_r[k-1][APG_LOG_FRAC-2:0], w_t[32]};
        end
    end

    assign o_valid = r_vld[APG_LOG_FRAC];
    assign o_lg    = {r_n[APG_LOG_FRAC], r_r[APG_LOG_FRAC]};

endmodule

// ===== src/apg_exp2.sv =====
// Pipelined power factor: 2^-(gamma * L) in Q0.16 from a Q.24 log difference.
// Depends on apg_pkg; one gamma multiply stage, one stage per fraction bit, one rounding stage.
module apg_exp2
    import apg_pkg::*;
#(
    parameter int GAMMA_FRAC_BITS = APG_GAMMA_FRAC_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [APG_LOG_W-1:0] i_lv,
    input  logic [15:0]          i_gamma,
    output logic                 o_valid,
    output logic [APG_FAC_W-1:0] o_fac
);

    localparam int PW = APG_LOG_W + 16;

    logic [APG_EXP_LEN+1:0]  r_vld;
    logic [32:0]             r_p   [APG_EXP_LEN+1];
    logic [APG_LOG_FRAC-1:0] r_f   [APG_EXP_LEN+1];
    logic [4:0]              r_ip  [APG_EXP_LEN+1];
    logic                    r_big [APG_EXP_LEN+1];
    logic [APG_FAC_W-1:0]    r_fac;

    logic [PW-1:0] w_prod;
    logic [PW-1:0] w_e;
    logic [32:0]   w_sh;
    logic [33:0]   w_rnd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[APG_EXP_LEN:0], i_valid};
        end
    end

    // Scale the log difference by gamma and split integer and fraction.
    assign w_prod = PW'(i_gamma) * PW'(i_lv);
    assign w_e    = w_prod >> GAMMA_FRAC_BITS;

    always_ff @(posedge i_clk) begin
        r_p[0]   <= 33'h1_0000_0000;
        r_f[0]   <= w_e[APG_LOG_FRAC-1:0];
        r_ip[0]  <= w_e[APG_LOG_FRAC+4:APG_LOG_FRAC];
        r_big[0] <= |w_e[PW-1:APG_LOG_FRAC+5];
    end

    // Each fraction bit multiplies in its root of two.
    for (genvar k = 1; k <= APG_EXP_LEN; k++) begin : g_bit
        localparam logic [31:0] TK = 32'(apg_exp_tab(k - 1));
        logic [64:0] w_m;
        assign w_m = 65'(r_p[k-1]) * 65'(TK);
        always_ff @(posedge i_clk) begin
            r_p[k]   <= r_f[k-1][APG_LOG_FRAC-k] ? w_m[64:32] : r_p[k-1];
            r_f[k]   <= r_f[k-1];
            r_ip[k]  <= r_ip[k-1];
            r_big[k] <= r_big[k-1];
        end
    end

    // Apply the integer part and round to Q0.16.
    assign w_sh  = r_p[APG_EXP_LEN] >> r_ip[APG_EXP_LEN];
    assign w_rnd = {1'b0, w_sh} + 34'h8000;

    always_ff @(posedge i_clk) begin
        r_fac <= r_big[APG_EXP_LEN] ? '0 : w_rnd[APG_FAC_W+15:16];
    end

    assign o_valid = r_vld[APG_EXP_LEN+1];
    assign o_fac   = r_fac;

endmodule

// ===== src/alpha_premultiply_gamma_core.sv =====
// Alpha premultiplication with gamma: top level, configuration registers and channel lanes.
// Depends on apg_pkg, apg_log2 and apg_exp2.
// An accepted word passes the input, log, log difference, exp, multiply and output stages.
// Throughput: one word per cycle, set by the fully pipelined log and exp units.
// busy never rises and the receiver cannot stall; results leave on o_valid alone.
// Reset is synchronous, active low; it restores the register defaults and clears all valids.
module alpha_premultiply_gamma_core
    import apg_pkg::*;
#(
    parameter int SAMPLE_WIDTH    = APG_SAMPLE_WIDTH,
    parameter int GAMMA_FRAC_BITS = APG_GAMMA_FRAC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [15:0] i_chan0_in,
    input  logic [15:0] i_chan1_in,
    input  logic [15:0] i_chan2_in,
    input  logic [15:0] i_chan3_in,
    input  logic        i_line_end_in,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_valid,
    output logic [15:0] o_chan0_out,
    output logic [15:0] o_chan1_out,
    output logic [15:0] o_chan2_out,
    output logic [15:0] o_chan3_out,
    output logic        o_line_end_out
);

    localparam logic [15:0] MAX_WIDE   = 16'((32'd1 << SAMPLE_WIDTH) - 1);
    localparam logic [15:0] MAX_NARROW = 16'd255;
    localparam logic [16:0] GAMMA_ONE  = 17'(32'd1 << GAMMA_FRAC_BITS);
    localparam logic [APG_LOG_W-1:0] LGM_WIDE   = APG_LOG_W'(apg_log2_const(64'(MAX_WIDE)));
    localparam logic [APG_LOG_W-1:0] LGM_NARROW = APG_LOG_W'(apg_log2_const(64'(MAX_NARROW)));
    localparam int SB_LEN = APG_LOG_LAT + 1 + APG_EXP_LAT;

    // Configuration registers.
    logic        r_assoc;
    logic        r_wide;
    logic [2:0]  r_count;
    logic [1:0]  r_alpha;
    logic [15:0] r_gamma;

    logic w_accept;
    logic w_cfg_wr;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_start && !o_busy;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_assoc <= RST_ASSOC;
            r_wide  <= RST_WIDE;
            r_count <= RST_COUNT;
            r_alpha <= RST_ALPHA;
            r_gamma <= RST_GAMMA;
        end else if (w_cfg_wr) begin
            unique case (i_cfg_index)
                CFG_ASSOC: r_assoc <= i_cfg_data[0];
                CFG_WIDE:  r_wide  <= i_cfg_data[0];
                CFG_COUNT: r_count <= i_cfg_data[2:0];
                CFG_ALPHA: r_alpha <= i_cfg_data[1:0];
                CFG_GAMMA: r_gamma <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input stage: mask samples, pick alpha and decide which lanes are scaled.
    logic [15:0] w_max;
    logic [2:0]  w_cc;
    logic        w_do;
    t_side       n_s0;
    t_side       r_s0;
    logic        r_s0_vld;

    always_comb begin
        w_max = r_wide ? MAX_WIDE : MAX_NARROW;
        if (r_count == 3'd0) begin
            w_cc = 3'd1;
        end else if (r_count > 3'd4) begin
            w_cc = 3'd4;
        end else begin
            w_cc = r_count;
        end
        w_do = r_assoc && ({1'b0, r_alpha} < w_cc);
        n_s0.chan[0]  = i_chan0_in & w_max;
        n_s0.chan[1]  = i_chan1_in & w_max;
        n_s0.chan[2]  = i_chan2_in & w_max;
        n_s0.chan[3]  = i_chan3_in & w_max;
        n_s0.line_end = i_line_end_in;
        n_s0.alpha    = n_s0.chan[r_alpha];
        for (int c = 0; c < 4; c++) begin
            n_s0.lanes[c] = w_do && (3'(c) < w_cc) && (2'(c) != r_alpha);
        end
        n_s0.int_path = ({1'b0, r_gamma} == GAMMA_ONE);
        n_s0.fac_one  = (r_gamma == 16'd0) || (n_s0.alpha == w_max);
        n_s0.fac_zero = (n_s0.alpha == 16'd0);
        n_s0.wide     = r_wide;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else begin
            r_s0_vld <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0 <= n_s0;
    end

    // Side data delay line, matched to the log and exp pipelines.
    logic [SB_LEN-1:0] r_sb_vld;
    t_side             r_sb [SB_LEN];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sb_vld <= '0;
        end else begin
            r_sb_vld <= {r_sb_vld[SB_LEN-2:0], r_s0_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_sb[0] <= r_s0;
        for (int i = 1; i < SB_LEN; i++) begin
            r_sb[i] <= r_sb[i-1];
        end
    end

    // Log of alpha.
    logic                 w_lg_vld;
    logic [APG_LOG_W-1:0] w_lg;

    apg_log2 u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s0_vld),
        .i_val   (r_s0.alpha),
        .o_valid (w_lg_vld),
        .o_lg    (w_lg)
    );

    // Log difference log2(max) - log2(alpha).
    logic                 r_lv_vld;
    logic [APG_LOG_W-1:0] r_lv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lv_vld <= 1'b0;
        end else begin
            r_lv_vld <= w_lg_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lv <= (r_sb[APG_LOG_LAT-1].wide ? LGM_WIDE : LGM_NARROW) - w_lg;
    end

    // Power factor.
    logic                 w_fac_vld;
    logic [APG_FAC_W-1:0] w_fac;

    apg_exp2 #(
        .GAMMA_FRAC_BITS (GAMMA_FRAC_BITS)
    ) u_exp2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_lv_vld),
        .i_lv    (r_lv),
        .i_gamma (r_gamma),
        .o_valid (w_fac_vld),
        .o_fac   (w_fac)
    );

    // Multiply stage: each lane times alpha or times the power factor.
    t_side                 w_tail;
    logic [APG_FAC_W-1:0]  w_op;
    logic                  r_m_vld;
    t_side                 r_m;
    logic [3:0][32:0]      r_prod;

    assign w_tail = r_sb[SB_LEN-1];

    always_comb begin
        if (w_tail.int_path) begin
            w_op = {1'b0, w_tail.alpha};
        end else if (w_tail.fac_one) begin
            w_op = 17'h1_0000;
        end else if (w_tail.fac_zero) begin
            w_op = '0;
        end else begin
            w_op = w_fac;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else begin
            r_m_vld <= r_sb_vld[SB_LEN-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_m <= w_tail;
        for (int c = 0; c < 4; c++) begin
            r_prod[c] <= 33'(w_tail.chan[c]) * 33'(w_op);
        end
    end

    // Output stage: divide by the maximum or drop the Q0.16 fraction, then select.
    logic [3:0][15:0] n_out;
    logic [3:0][33:0] w_sum_n;
    logic [3:0][33:0] w_sum_w;
    logic [3:0][15:0] r_out;
    logic             r_q_vld;
    logic             r_q_le;
    logic             r_q_wide;

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            w_sum_n[c] = {1'b0, r_prod[c]} + ({1'b0, r_prod[c]} >> 8) + 34'd1;
            w_sum_w[c] = {1'b0, r_prod[c]} + ({1'b0, r_prod[c]} >> SAMPLE_WIDTH) + 34'd1;
            if (!r_m.lanes[c]) begin
                n_out[c] = r_m.chan[c];
            end else if (!r_m.int_path) begin
                n_out[c] = r_prod[c][31:16];
            end else if (r_m.wide) begin
                n_out[c] = 16'(w_sum_w[c] >> SAMPLE_WIDTH);
            end else begin
                n_out[c] = w_sum_n[c][23:8];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_vld <= 1'b0;
        end else begin
            r_q_vld <= r_m_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out    <= n_out;
        r_q_le   <= r_m.line_end;
        r_q_wide <= r_m.wide;
    end

    assign o_valid        = r_q_vld;
    assign o_chan0_out    = r_out[0];
    assign o_chan1_out    = r_out[1];
    assign o_chan2_out    = r_out[2];
    assign o_chan3_out    = r_out[3];
    assign o_line_end_out = r_q_le;

`ifndef SYNTH
    // The power factor must line up with the side data that it scales.
    a_fac_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fac_vld == r_sb_vld[SB_LEN-1])
        else $error("power factor out of step with side data");

    // Every result word comes from a factor that went through the multiply and output stages.
    a_out_from_fac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_fac_vld, 2))
        else $error("result word without a matching factor");

    // Narrow samples never produce bits above the low byte.
    a_narrow_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !r_q_wide) |-> ((o_chan0_out[15:8] == 8'd0) && (o_chan1_out[15:8] == 8'd0)
            && (o_chan2_out[15:8] == 8'd0) && (o_chan3_out[15:8] == 8'd0)))
        else $error("narrow result exceeds sample maximum");
`endif

endmodule

// ===== test/alpha_premultiply_gamma_core_tb.sv =====
// Testbench for alpha_premultiply_gamma_core: drives pixel words, predicts each result in
// a local model of the premultiply and log/exp power path, and compares every result strobe.
// Depends on apg_pkg and the core RTL only.
`timescale 1ns / 1ps

module alpha_premultiply_gamma_core_tb;
    import apg_pkg::*;

    localparam int DRAIN_CYCLES = 80;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic [15:0] i_chan0_in, i_chan1_in, i_chan2_in, i_chan3_in;
    logic        i_line_end_in;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        o_valid;
    logic [15:0] o_chan0_out, o_chan1_out, o_chan2_out, o_chan3_out;
    logic        o_line_end_out;

    typedef struct packed {
        logic [3:0][15:0] chan;
        logic             line_end;
    } t_pixel;

    // Local copy of the configuration registers.
    logic        assoc_q;
    logic        wide_q;
    logic [2:0]  count_q;
    logic [1:0]  alpha_q;
    logic [15:0] gamma_q;

    t_pixel      premult_expected[$];
    logic [63:0] exp_tab[APG_EXP_LEN];
    int          error_count;
    int          checked_count;
    int          idle_pct;

    alpha_premultiply_gamma_core u_dut (.*);

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Overall time limit.
    initial begin
        #20ms;
        $display("Timeout at %0t", $time);
        $display("RESULT: ERROR");
        $finish;
    end

    // Integer square root rounded down.
    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = '0;
        bitv = 64'h4000_0000_0000_0000;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // floor(log2(v) * 2^24) by repeated squaring of the mantissa.
    function automatic logic [63:0] log2_q24(input logic [63:0] v);
        int unsigned n;
        logic [63:0] m;
        logic [63:0] r;
        n = 0;
        r = '0;
        while (n < 31 && (v >> (n + 1)) != 0) n++;
        m = v << (31 - n);
        for (int i = 0; i < APG_LOG_FRAC; i++) begin
            m = (m * m) >> 31;
            r = r << 1;
            if (m >= 64'h1_0000_0000) begin
                r = r | 64'd1;
                m = m >> 1;
            end
        end
        return (64'(n) << APG_LOG_FRAC) | r;
    endfunction

    // (a/maxv)^gamma in Q0.16.
    function automatic logic [63:0] gamma_factor(input logic [63:0] a, input logic [63:0] maxv,
                                                 input logic [63:0] g);
        logic [63:0] l, e, ip, f, p;
        l  = log2_q24(maxv) - log2_q24(a);
        e  = (g * l) >> APG_GAMMA_FRAC_BITS;
        ip = e >> APG_LOG_FRAC;
        f  = e & ((64'd1 << APG_LOG_FRAC) - 1);
        p  = 64'd1 << 32;
        if (ip >= 32) return 64'd0;
        for (int k = 0; k < APG_EXP_LEN; k++) begin
            if (f[APG_LOG_FRAC-1-k]) p = (p * exp_tab[k]) >> 32;
        end
        p = p >> ip;
        return (p + 64'h8000) >> 16;
    endfunction

    // Expected output word for one input word under the current registers.
    function automatic t_pixel premultiply(input t_pixel px);
        logic [63:0] maxv, a, fac;
        logic [63:0] s[4];
        int          cc;
        t_pixel      res;
        maxv = wide_q ? 64'hFFFF : 64'd255;
        for (int c = 0; c < 4; c++) s[c] = 64'(px.chan[c]) & maxv;
        cc = (count_q == 0) ? 1 : (count_q > 4 ? 4 : int'(count_q));
        if (assoc_q && int'(alpha_q) < cc) begin
            a = s[alpha_q];
            if (gamma_q == 16'(1 << APG_GAMMA_FRAC_BITS)) begin
                for (int c = 0; c < cc; c++)
                    if (c != int'(alpha_q)) s[c] = (s[c] * a) / maxv;
            end else begin
                if (gamma_q == 0 || a == maxv) fac = 64'd65536;
                else if (a == 0) fac = 64'd0;
                else fac = gamma_factor(a, maxv, 64'(gamma_q));
                for (int c = 0; c < cc; c++)
                    if (c != int'(alpha_q)) s[c] = (s[c] * fac) >> 16;
            end
        end
        for (int c = 0; c < 4; c++) res.chan[c] = s[c][15:0];
        res.line_end = px.line_end;
        return res;
    endfunction

    // Compare each result strobe with the oldest expected word.
    always @(posedge i_clk) begin
        t_pixel got, want;
        if (i_rst_n && o_valid) begin
            got.chan     = {o_chan3_out, o_chan2_out, o_chan1_out, o_chan0_out};
            got.line_end = o_line_end_out;
            if (premult_expected.size() == 0) begin
                $display("%0t: expected no word, actual %h", $time, got);
                error_count++;
            end else begin
                want = premult_expected.pop_front();
                checked_count++;
                for (int c = 0; c < 4; c++)
                    if (got.chan[c] !== want.chan[c]) begin
                        $display("%0t: chan%0d expected %h actual %h", $time, c,
                                 want.chan[c], got.chan[c]);
                        error_count++;
                    end
                if (got.line_end !== want.line_end) begin
                    $display("%0t: line_end expected %b actual %b", $time,
                             want.line_end, got.line_end);
                    error_count++;
                end
            end
        end
    end

    // Write one configuration register; the model follows on the handshake.
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_ASSOC: assoc_q = data[0];
            CFG_WIDE:  wide_q  = data[0];
            CFG_COUNT: count_q = data[2:0];
            CFG_ALPHA: alpha_q = data[1:0];
            CFG_GAMMA: gamma_q = data;
            default: ;
        endcase
    endtask

    // Write all registers back to back, then release the write channel.
    task automatic set_config(input logic assoc, input logic wide, input logic [2:0] cnt,
                              input logic [1:0] alpha, input logic [15:0] gamma);
        write_reg(CFG_ASSOC, 16'(assoc));
        write_reg(CFG_WIDE, 16'(wide));
        write_reg(CFG_COUNT, 16'(cnt));
        write_reg(CFG_ALPHA, 16'(alpha));
        write_reg(CFG_GAMMA, gamma);
        i_cfg_valid <= 1'b0;
    endtask

    // Send one word, with a random idle gap before it. start stays high for a word that
    // follows directly; the idle loop or the drain drops it.
    task automatic send_pixel(input t_pixel px);
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start       <= 1'b1;
        i_chan0_in    <= px.chan[0];
        i_chan1_in    <= px.chan[1];
        i_chan2_in    <= px.chan[2];
        i_chan3_in    <= px.chan[3];
        i_line_end_in <= px.line_end;
        do @(posedge i_clk); while (o_busy);
        premult_expected.insert(premult_expected.size(), premultiply(px));
    endtask

    // Wait until every expected word has come back, then let the pipeline empty.
    task automatic drain;
        i_start <= 1'b0;
        while (premult_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_pixel random_pixel();
        t_pixel px;
        for (int c = 0; c < 4; c++) begin
            case ($urandom_range(5))
                0: px.chan[c] = 16'h0000;
                1: px.chan[c] = 16'hFFFF;
                2: px.chan[c] = 16'h00FF;
                default: px.chan[c] = 16'($urandom);
            endcase
        end
        px.line_end = 1'($urandom);
        return px;
    endfunction

    // Extremes of the samples under the reset registers and a few key settings.
    task automatic test_directed;
        t_pixel px;
        idle_pct = 0;
        for (int g = 0; g < 4; g++) begin
            case (g)
                0: set_config(1'b1, 1'b0, 3'd4, 2'd3, RST_GAMMA);
                1: set_config(1'b1, 1'b1, 3'd4, 2'd3, 16'd4096);
                2: set_config(1'b1, 1'b1, 3'd4, 2'd0, 16'd0);
                default: set_config(1'b0, 1'b0, 3'd7, 2'd1, 16'hFFFF);
            endcase
            for (int k = 0; k < 6; k++) begin
                px.chan     = {16'hFFFF, 16'h0000, 16'h8001, 16'h00FF};
                px.line_end = k[0];
                case (k)
                    0: px.chan[alpha_q] = 16'h0000;
                    1: px.chan[alpha_q] = 16'hFFFF;
                    2: px.chan[alpha_q] = 16'h00FF;
                    3: px.chan[alpha_q] = 16'h0001;
                    4: px.chan[alpha_q] = 16'h7F80;
                    default: px.chan = {16'hAAAA, 16'h5555, 16'hFFFF, 16'h0000};
                endcase
                send_pixel(px);
            end
            drain();
        end
    endtask

    // Random words through random settings, including out-of-range counts.
    task automatic test_random(input int pct, input int words);
        logic [15:0] gamma;
        idle_pct = pct;
        for (int b = 0; b < 5; b++) begin
            case ($urandom_range(5))
                0: gamma = 16'd4096;
                1: gamma = 16'd0;
                2: gamma = 16'hFFFF;
                3: gamma = 16'd1;
                default: gamma = 16'($urandom);
            endcase
            set_config($urandom_range(9) != 0, 1'($urandom), 3'($urandom),
                       2'($urandom), gamma);
            for (int i = 0; i < words / 5; i++) send_pixel(random_pixel());
            drain();
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_start       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= CFG_ASSOC;
        i_cfg_data    <= '0;
        i_chan0_in    <= '0;
        i_chan1_in    <= '0;
        i_chan2_in    <= '0;
        i_chan3_in    <= '0;
        i_line_end_in <= 1'b0;
        assoc_q = RST_ASSOC;
        wide_q  = RST_WIDE;
        count_q = RST_COUNT;
        alpha_q = RST_ALPHA;
        gamma_q = RST_GAMMA;
        error_count   = 0;
        checked_count = 0;
        idle_pct      = 0;
        exp_tab[0] = floor_sqrt(64'h8000_0000_0000_0000);
        for (int k = 1; k < APG_EXP_LEN; k++) exp_tab[k] = floor_sqrt(exp_tab[k-1] << 32);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(0, 300);
        test_random(74, 300);
        test_random(26, 250);
        test_random(0, 250);

        $display("Checked %0d words over directed extremes and random settings,", checked_count);
        $display("with sender gaps at 0, 26 and 74 percent.");
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
